[design/sspq_pkg.sv]
// shared types and constants for the sorted shift priority queue
package sspq_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned CAP_W   = 6;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 6'd20;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } t_req_beat;

    typedef struct packed {
        logic signed [KEY_W-1:0] data;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
    } t_rsp_beat;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[design/sspq_ctrl.sv]
// controller: accept and execute sequencing plus output valid
module sspq_ctrl
    import sspq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load, w_exec;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_load      = 1'b0;
        w_exec      = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_load  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    w_exec      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_load;
    assign o_cmd.exec  = w_exec;

endmodule

[design/sspq_dp.sv]
// datapath: sorted entry cells, fill count, capacity and result register
module sspq_dp
    import sspq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_req_beat        i_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output t_rsp_beat        o_rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

    t_req_beat               r_req;
    logic signed [KEY_W-1:0] r_entries [DEPTH];
    logic signed [KEY_W-1:0] n_entries [DEPTH];
    logic [CW-1:0]           r_count, n_count;
    logic [CAP_W-1:0]        r_capacity;
    t_rsp_beat               r_rsp, n_rsp;

    logic [DEPTH-1:0]        w_greater;
    logic [MW-1:0]           w_count_ext;
    logic [MW-1:0]           w_cap_ext;
    logic [MW-1:0]           w_idx_ext;
    logic [MW-1:0]           w_depth_ext;
    logic signed [KEY_W-1:0] w_rd_data;

    assign w_count_ext = MW'(r_count);
    assign w_cap_ext   = MW'(r_capacity);
    assign w_idx_ext   = MW'(r_req.index);
    assign w_depth_ext = MW'(DEPTH);

    // per cell compare, only live cells take part
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_greater[i] = (MW'(i) < w_count_ext) && (r_req.value > r_entries[i]);
        end
    end

    always_comb begin
        w_rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_idx_ext == MW'(i)) begin
                w_rd_data = r_entries[i];
            end
        end
    end

    always_comb begin
        n_entries   = r_entries;
        n_count     = r_count;
        n_rsp.data  = '0;
        n_rsp.status = ST_OK;
        case (r_req.req_type)
            REQ_PUSH: begin
                if (w_count_ext >= w_cap_ext || w_count_ext >= w_depth_ext) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_greater[i] || (MW'(i) == w_count_ext)) begin
                            if (i > 0 && w_greater[(i > 0) ? i - 1 : 0]) begin
                                n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                            end else begin
                                n_entries[i] = r_req.value;
                            end
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.data = r_entries[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_entries[i] = r_entries[i + 1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            REQ_READ: begin
                if (w_idx_ext >= w_count_ext) begin
                    n_rsp.status = ST_RANGE;
                end else begin
                    n_rsp.data = w_rd_data;
                end
            end
            default: begin
            end
        endcase
        n_rsp.count = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_entries <= n_entries;
            r_rsp     <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAPACITY_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

[design/sorted_shift_priority_queue_unit.sv]
// top level of the sorted shift priority queue
// Sorted priority queue of up to DEPTH signed 32-bit keys held in a row of
// registers in descending order, highest key at position 0. A push drops the
// new key in behind every key that is not smaller (equal keys leave in
// arrival order), a pop returns position 0 and moves the rest forward, and a
// read returns the key at the requested position. Every request beat gives
// exactly one result beat: data, status (ok, full push dropped, empty pop,
// index out of range) and the fill count after the request. Each request is
// first registered, then executed in a step in which every cell compares
// and shifts in parallel and the result register loads, once that register
// is free or draining; the next request is taken as soon as the result is
// registered, even while that result still waits for the sink. The capacity
// register (reset 20) limits how many keys are kept; values above DEPTH act
// as DEPTH, and it may only be written while no request is in flight.
module sorted_shift_priority_queue_unit
    import sspq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req_beat        i_in_data,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp_beat        o_out_data,
    // capacity register write
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;

    // sequencing of accept and execute
    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // entry cells, count, capacity and result register
    sspq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_out_data)
    );

    // an accepted beat keeps the input closed for the execute cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // the execute step always leaves a result behind
    a_exec_loads_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_out_valid)
        else $error("execute without result");

    // any error status carries zero data
    a_error_zero_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.data == '0))
        else $error("error result with nonzero data");

endmodule
